>>> rtl/rhef_pkg.sv
// Package: default sizes and the build-time Hann tap function of the envelope FIR.
`timescale 1ns / 1ps

package rhef_pkg;

  localparam int WINDOW_LEN_DEF     = 30;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 15;

  localparam real HANN_PI = 3.141592653589793238460;

  // Periodic Hann tap, rounded to unsigned Q1.frac; step is 2*pi/n.
  // Folded about n/2 so the cosine argument stays small.
  function automatic int hann_tap(real step, int n, int i, int frac);
    int  m;
    real v;
    m = i;
    if (2 * m > n) begin
      m = n - m;
    end
    v = (0.5 - 0.5 * $cos(step * m)) * (2.0 ** frac);
    return $rtoi(v + 0.5);
  endfunction

endpackage

>>> rtl/rectified_hann_envelope_fir_unit.sv
// Top level: rectified Hann-window FIR envelope detector, pipelined multiply and adder tree.
`timescale 1ns / 1ps

// Envelope detector. Each sample transfer on the in_ channel (signed sample in
// in_tdata, block start flag in in_tuser) shifts the sample magnitude into a
// WINDOW_LEN-deep delay line; once WINDOW_LEN samples of the current block have
// arrived, every further sample yields one out_ transfer carrying the exact,
// unscaled sum of the line times a fixed periodic Hann window (newest sample
// on tap 0). Until the window is full after reset or a block start, samples
// give no result. Throughput is one sample per clock while the output is not
// stalled. The delay line is written at the input transfer edge itself, then
// the constant-tap multipliers register their products, then each level of
// the registered adder tree in turn, whose root is the output register.
// Every stage has its own valid bit, so a stalled output only holds back the
// input once all stages in between are full.
module rectified_hann_envelope_fir_unit #(
  parameter int WINDOW_LEN     = rhef_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS    = rhef_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = rhef_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [SAMPLE_BITS-1:0] sample (signed); zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  // [0] block_start
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [ENV_W-1:0] envelope; zero padding above
  output logic [((SAMPLE_BITS+COEF_FRAC_BITS-1+$clog2(WINDOW_LEN)+7)/8)*8-1:0] out_tdata
);

  import rhef_pkg::*;

  localparam int LVLS    = $clog2(WINDOW_LEN);
  localparam int NP      = 2 ** LVLS;
  localparam int TAP_W   = COEF_FRAC_BITS + 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int ENV_W   = SAMPLE_BITS + COEF_FRAC_BITS - 1 + LVLS;
  localparam int OUT_W   = ((ENV_W + 7) / 8) * 8;
  localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
  localparam real HANN_STEP = 2.0 * HANN_PI / WINDOW_LEN;

  // delay line (stage 1)
  logic [SAMPLE_BITS-1:0] mag_r [WINDOW_LEN];
  logic                   line_vld_r;
  logic [FILL_W-1:0]      fill_r;

  // heap-ordered adder tree: node k has children 2k+1, 2k+2; leaves from NP-1
  logic [ENV_W-1:0]       node_r [2*NP-1];
  logic [LVLS:0]          vld_r;     // index is tree depth, 0 = root

  logic [LVLS+1:0]        chain;     // chain[d+1]: depth d may load
  logic [LVLS+1:0]        vsrc;
  logic [SAMPLE_BITS-1:0] sample_u;
  logic [SAMPLE_BITS-1:0] mag_nxt;
  logic [FILL_W-1:0]      fill_base;
  logic [FILL_W-1:0]      fill_nxt;
  logic                   fire;
  logic                   in_xfer;

  // ---- handshake chain ----
  always_comb begin
    chain[0] = out_tready;
    for (int d = 0; d <= LVLS; d++) begin
      chain[d+1] = !vld_r[d] || chain[d];
    end
  end

  assign vsrc      = {line_vld_r, vld_r};
  assign in_tready = !line_vld_r || chain[LVLS+1];
  assign in_xfer   = in_tvalid && in_tready;

  // ---- rectify and fill count ----
  assign sample_u = in_tdata[SAMPLE_BITS-1:0];
  // most negative code maps to 2^(SAMPLE_BITS-1), still fits unsigned
  assign mag_nxt  = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;

  always_comb begin
    fill_base = in_tuser ? '0 : fill_r;
    fill_nxt  = (fill_base < FILL_W'(WINDOW_LEN)) ? fill_base + 1'b1 : fill_base;
    fire      = (fill_nxt == FILL_W'(WINDOW_LEN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      line_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        fill_r     <= fill_nxt;
        line_vld_r <= fire;
      end else if (chain[LVLS+1]) begin
        line_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r[0] <= mag_nxt;
      for (int j = 1; j < WINDOW_LEN; j++) begin
        mag_r[j] <= mag_r[j-1];
      end
    end
  end

  // ---- stage valids ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int d = 0; d <= LVLS; d++) begin
        if (chain[d+1]) begin
          vld_r[d] <= vsrc[d+1];
        end
      end
    end
  end

  // ---- constant-tap products (tree leaves) ----
  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < WINDOW_LEN) begin : g_tap
      localparam logic [TAP_W-1:0] TAP =
        TAP_W'(hann_tap(HANN_STEP, WINDOW_LEN, j, COEF_FRAC_BITS));
      always_ff @(posedge clk) begin
        if (chain[LVLS+1]) begin
          node_r[NP-1+j] <= ENV_W'(PROD_W'(mag_r[j]) * PROD_W'(TAP));
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[NP-1+j] <= '0;
      end
    end
  end

  // ---- adder tree levels ----
  for (genvar k = 0; k < NP - 1; k++) begin : g_node
    localparam int DEPTH = $clog2(k + 2) - 1;
    always_ff @(posedge clk) begin
      if (chain[DEPTH+1]) begin
        node_r[k] <= node_r[2*k+1] + node_r[2*k+2];
      end
    end
  end

  assign out_tvalid = vld_r[0];
  assign out_tdata  = OUT_W'(node_r[0]);

  // ---- assertions ----
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_LEN))
    else $error("fill count beyond window size");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && fire) |=> line_vld_r)
    else $error("full window did not launch a result");

  a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser) |=> (fill_r == FILL_W'(1)))
    else $error("block start did not restart the fill count");

  a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(mag_r[0]))
    else $error("delay line moved without an input transfer");

endmodule

>>> tb/sv/rectified_hann_envelope_fir_unit_tb.sv
// Testbench for the rectified Hann-window envelope FIR: streamed samples, predicted envelopes.
`timescale 1ns / 1ps

module rectified_hann_envelope_fir_unit_tb;

  import rhef_pkg::*;

  localparam int WIN      = WINDOW_LEN_DEF;
  localparam int SB       = SAMPLE_BITS_DEF;
  localparam int CF       = COEF_FRAC_BITS_DEF;
  localparam int ENV_W    = SB + CF - 1 + $clog2(WIN);
  localparam int IN_W     = ((SB + 7) / 8) * 8;
  localparam int OUT_W    = ((ENV_W + 7) / 8) * 8;
  // input transfer to out_tvalid, used to size the final drain wait
  localparam int LATENCY  = 1 + $clog2(WIN);
  localparam int RANDOM_ITEMS = 1300;
  // long receiver hold-off, so the pipeline fills and in_tready drops
  localparam int HOLD_CYCLES  = 64;
  localparam int HOLD_AFTER   = 150;
  // stretch of transfers with no random idling on either side
  localparam int STEADY_FROM  = 600;
  localparam int STEADY_TO    = 900;

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          block_start;
  } sample_item_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // [15:0] sample (signed)
  logic             in_tuser   = 1'b0; // [0] block_start
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // [34:0] envelope; zero padding above

  rectified_hann_envelope_fir_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Samples waiting to be offered, and envelopes still owed by the block.
  sample_item_t     sample_backlog[$];
  logic [ENV_W-1:0] envelope_due[$];

  // Own copy of the filter state: magnitude line (entry 0 newest), fill count, taps.
  logic [SB-1:0] mag_line[WIN];
  logic [4:0]    fill_cnt;
  logic [15:0]   hann_coef[WIN];

  int   samples_taken = 0;
  int   results_seen  = 0;
  int   errors        = 0;
  logic in_taken      = 1'b0;
  logic hold_off      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Synchronous reset, released on a falling edge.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Periodic Hann taps rounded to Q1.15; the value is never at a rounding midpoint.
  initial begin
    for (int i = 0; i < WIN; i++) begin
      hann_coef[i] = 16'($rtoi((0.5 - 0.5 * $cos(2.0 * HANN_PI * i / WIN))
                               * (2.0 ** CF) + 0.5));
      mag_line[i]  = '0;
    end
    fill_cnt = '0;
  end

  // Shift one sample's magnitude in; return 1 with the envelope once the window is full.
  function automatic bit shift_and_sum(input logic [SB-1:0] s, input logic restart,
                                       output logic [ENV_W-1:0] env);
    logic [SB:0]  wide;
    logic [63:0]  acc;
    wide = {1'b0, s};
    if (restart) begin
      fill_cnt = '0;
    end
    for (int j = WIN - 1; j > 0; j--) begin
      mag_line[j] = mag_line[j-1];
    end
    // -32768 rectifies to 32768, which still fits the unsigned entry
    mag_line[0] = s[SB-1] ? SB'((1 << SB) - wide) : s;
    if (fill_cnt < WIN) begin
      fill_cnt = fill_cnt + 1'b1;
    end
    env = '0;
    if (fill_cnt < WIN) begin
      return 1'b0;
    end
    acc = '0;
    for (int j = 0; j < WIN; j++) begin
      acc += 64'(mag_line[j]) * 64'(hann_coef[j]);
    end
    env = acc[ENV_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    logic [SB-1:0] corner[5];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    case ($urandom_range(9))
      0: return corner[$urandom_range(4)];
      1: return $urandom_range(1) ? SB'($urandom_range(15)) : -SB'($urandom_range(16));
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic queue_sample(input logic [SB-1:0] s, input logic restart);
    sample_item_t it;
    it.sample      = s;
    it.block_start = restart;
    sample_backlog.push_back(it);
  endtask

  // Sender: a new sample goes out on a falling edge once the previous one has
  // transferred; about 8 % of the free slots are left idle.
  always @(negedge clk) begin : sender
    sample_item_t nxt;
    logic         steady;
    steady = samples_taken >= STEADY_FROM && samples_taken < STEADY_TO;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
        nxt = sample_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_W'(nxt.sample);
        in_tuser  <= nxt.block_start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, none in the steady stretch, none at all
  // while the long hold-off is running (then out_tready stays low).
  always @(negedge clk) begin : receiver
    logic steady;
    steady = results_seen >= STEADY_FROM && results_seen < STEADY_TO;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && (steady || $urandom_range(99) >= 8);
    end
  end

  // Long hold-off, counted in cycles here; the sender keeps offering samples.
  initial begin
    wait (results_seen >= HOLD_AFTER);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: predict on each sample transfer, check each envelope transfer
  // against the oldest envelope owed.
  always @(posedge clk) begin : monitor
    logic [ENV_W-1:0] env;
    logic [ENV_W-1:0] want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (shift_and_sum(in_tdata[SB-1:0], in_tuser, env)) begin
          envelope_due.push_back(env);
        end
        samples_taken <= samples_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (envelope_due.size() == 0) begin
          $error("envelope: none expected, got %0d", out_tdata[ENV_W-1:0]);
          errors++;
        end else begin
          want = envelope_due.pop_front();
          if (out_tdata[ENV_W-1:0] !== want) begin
            $error("envelope: expected %0d, got %0d", want, out_tdata[ENV_W-1:0]);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int total;
    int len;
    int kind;
    int random_left;
    int guard;

    // Full window of the most negative sample: largest envelope.
    for (int i = 0; i < WIN; i++) begin
      queue_sample(16'h8000, 1'b0);
    end
    queue_sample(16'h7fff, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h0001, 1'b0);
    queue_sample(16'hffff, 1'b0);
    // block start with a block too short to fill the window, then another
    queue_sample(16'h7fff, 1'b1);
    queue_sample(16'h8001, 1'b0);
    queue_sample(16'h1234, 1'b0);

    // Mostly well-formed blocks long enough to fill and then saturate the
    // count; some short broken blocks and some runs with no block start.
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      kind = $urandom_range(9);
      if (kind < 8) begin
        len = $urandom_range(90, WIN);
      end else if (kind == 8) begin
        len = $urandom_range(WIN - 1, 1);
      end else begin
        len = $urandom_range(40, 1);
      end
      for (int i = 0; i < len; i++) begin
        queue_sample(pick_sample(), kind != 9 && i == 0);
      end
      random_left -= len;
    end
    total = sample_backlog.size();

    wait (samples_taken == total);
    guard = 0;
    while (envelope_due.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    // then wait on, to catch any stray envelope
    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0 && envelope_due.size() == 0) begin
      $display("PASS rectified_hann_envelope_fir_unit");
    end else begin
      $display("FAIL rectified_hann_envelope_fir_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL rectified_hann_envelope_fir_unit");
    $finish;
  end

endmodule

>>> sim.f
rtl/rhef_pkg.sv
rtl/rectified_hann_envelope_fir_unit.sv
tb/sv/rectified_hann_envelope_fir_unit_tb.sv
